// File: rtl/core/frx_pkg.sv
package frx_pkg;

  localparam logic [7:0] DELIM       = 8'h7E;
  localparam logic [7:0] TYPE_PING   = 8'h50;  // 'P'
  localparam logic [7:0] TYPE_IN     = 8'h49;  // 'I'
  localparam logic [7:0] TYPE_OUT    = 8'h4F;  // 'O'
  localparam logic [7:0] CHAN_ALL    = 8'hFF;
  localparam logic [7:0] CHAN_ANY    = 8'h00;
  localparam logic [7:0] HDR_LEN     = 8'd12;
  localparam logic [7:0] PING_MIN    = 8'd2;

  localparam logic CFG_OWN_ID      = 1'b0;
  localparam logic CFG_OWN_CHANNEL = 1'b1;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_HDR   = 2'd1,
    KIND_PAY   = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CLASS,
    B_SEARCH,
    B_DECIDE,
    B_ONE,
    B_HDR,
    B_RD,
    B_PAY,
    B_DONE
  } back_state_t;

  // Completed frame as handed from the parser to the table engine
  typedef struct packed {
    logic [7:0]  len;
    logic [7:0]  ftype;
    logic [7:0]  wired;
    logic [7:0]  channel;
    logic [7:0]  dev_type;
    logic [63:0] addr;
  } frame_desc_t;

  // One result as driven towards the output register
  typedef struct packed {
    kind_t      kind;
    logic [3:0] entry_index;
    logic [7:0] net_number;
    logic       is_new;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// File: rtl/core/frx_front.sv
module frx_front #(
  parameter int FRAME_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_op,
  input  logic [7:0]                     in_byte,
  output logic                           in_ready,
  output logic                           desc_valid,
  output frx_pkg::frame_desc_t           desc,
  input  logic                           back_done,
  input  logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
  output logic [7:0]                     rd_data
);

  localparam int AW = $clog2(FRAME_BYTES);

  frx_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] wpos_r, wpos_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] hdr_r [12];
  logic [7:0] store [FRAME_BYTES];
  logic       acc;
  logic       wr_en;

  assign in_ready   = !pend_r;
  assign acc        = in_valid && in_ready;
  assign desc_valid = pend_r;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    wpos_nxt  = wpos_r;
    pend_nxt  = pend_r && !back_done;
    len_nxt   = len_r;
    wr_en     = 1'b0;
    if (acc) begin
      if (in_op) begin
        phase_nxt = frx_pkg::PH_HUNT;
        left_nxt  = '0;
        wpos_nxt  = '0;
      end else begin
        case (phase_r)
          frx_pkg::PH_LEN: begin
            if (in_byte == 8'd0 || 32'(in_byte) > FRAME_BYTES) begin
              phase_nxt = frx_pkg::PH_HUNT;
            end else begin
              left_nxt  = in_byte;
              wpos_nxt  = '0;
              phase_nxt = frx_pkg::PH_BODY;
            end
          end
          frx_pkg::PH_BODY: begin
            wr_en    = 32'(wpos_r) < FRAME_BYTES;
            wpos_nxt = wpos_r + 8'd1;
            left_nxt = (left_r != 8'd0) ? left_r - 8'd1 : left_r;
            if (left_nxt == 8'd0) begin
              phase_nxt = frx_pkg::PH_HUNT;
              wpos_nxt  = '0;
              // hand the frame over and hold input until it is consumed
              if (32'(wpos_r) < FRAME_BYTES) begin
                len_nxt  = wpos_r + 8'd1;
                pend_nxt = 1'b1;
              end
            end
          end
          default: begin
            phase_nxt = (in_byte == frx_pkg::DELIM) ? frx_pkg::PH_LEN : frx_pkg::PH_HUNT;
            if (in_byte == frx_pkg::DELIM) begin
              wpos_nxt = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= frx_pkg::PH_HUNT;
      left_r  <= '0;
      wpos_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      wpos_r  <= wpos_nxt;
      pend_r  <= pend_nxt;
    end
    len_r <= len_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wpos_r[AW-1:0]] <= in_byte;
      if (wpos_r < frx_pkg::HDR_LEN) begin
        hdr_r[wpos_r[3:0]] <= in_byte;
      end
    end
    rd_data <= store[rd_addr];
  end

  assign desc.len      = len_r;
  assign desc.ftype    = hdr_r[0];
  assign desc.wired    = hdr_r[1];
  assign desc.channel  = hdr_r[2];
  assign desc.dev_type = hdr_r[3];
  assign desc.addr     = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7],
                          hdr_r[8], hdr_r[9], hdr_r[10], hdr_r[11]};

endmodule

// File: rtl/core/frx_back.sv
module frx_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int FRAME_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [7:0]                     own_id,
  input  logic [7:0]                     own_channel,
  input  logic                           desc_valid,
  input  frx_pkg::frame_desc_t           desc,
  output logic                           back_done,
  output logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  output logic                           res_valid,
  output frx_pkg::result_t               res,
  input  logic                           res_ready
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  frx_pkg::back_state_t st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    netc_r, netc_nxt;
  logic [7:0]    net_r, net_nxt;
  logic          have_r, have_nxt;
  logic          fresh_r, fresh_nxt;
  logic [7:0]    pay_r, pay_nxt;
  logic          ov_r, ov_nxt;
  frx_pkg::result_t out_r, out_nxt;
  frx_pkg::kind_t   one_r, one_nxt;

  logic [63:0] t_addr [TABLE_DEPTH];
  logic [7:0]  t_wired [TABLE_DEPTH];
  logic [7:0]  t_type [TABLE_DEPTH];
  logic [7:0]  t_net [TABLE_DEPTH];
  logic        t_we;
  logic [63:0] w_addr;
  logic [7:0]  w_net;

  logic        out_free;
  logic        is_in;
  logic        chan_ok;
  logic [7:0]  pay_total;
  logic [IW-1:0] ri;
  logic        addr_eq, id_eq;

  assign out_free  = !ov_r || res_ready;
  assign is_in     = desc.ftype == frx_pkg::TYPE_IN;
  assign chan_ok   = desc.channel == own_channel || desc.channel == frx_pkg::CHAN_ALL ||
                     desc.channel == frx_pkg::CHAN_ANY || own_channel == frx_pkg::CHAN_ALL;
  assign pay_total = desc.len - frx_pkg::HDR_LEN;
  assign ri        = idx_r[IW-1:0];
  assign addr_eq   = t_addr[ri] == (is_in ? desc.addr : 64'd0);
  assign id_eq     = t_wired[ri] == desc.wired && t_type[ri] == desc.dev_type;
  assign rd_addr   = AW'({1'b0, pay_r} + {1'b0, frx_pkg::HDR_LEN});
  assign back_done = st_r == frx_pkg::B_DONE;
  assign res_valid = ov_r;
  assign res       = out_r;

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    netc_nxt  = netc_r;
    net_nxt   = net_r;
    have_nxt  = have_r;
    fresh_nxt = fresh_r;
    pay_nxt   = pay_r;
    one_nxt   = one_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r && !res_ready;
    t_we      = 1'b0;
    w_addr    = is_in ? desc.addr : 64'd0;
    w_net     = 8'd1;
    case (st_r)
      frx_pkg::B_IDLE: begin
        if (desc_valid) begin
          st_nxt = frx_pkg::B_CLASS;
        end
      end
      frx_pkg::B_CLASS: begin
        idx_nxt  = '0;
        have_nxt = 1'b0;
        st_nxt   = frx_pkg::B_DONE;
        if (desc.ftype == frx_pkg::TYPE_PING) begin
          if (desc.len >= frx_pkg::PING_MIN && desc.wired == own_id) begin
            one_nxt = frx_pkg::KIND_GRANT;
            st_nxt  = frx_pkg::B_ONE;
          end
        end else if ((is_in || desc.ftype == frx_pkg::TYPE_OUT) &&
                     desc.len >= frx_pkg::HDR_LEN && chan_ok) begin
          st_nxt = frx_pkg::B_SEARCH;
        end
      end
      frx_pkg::B_SEARCH: begin
        if (idx_r == cnt_r) begin
          st_nxt = frx_pkg::B_DECIDE;
        end else begin
          if (addr_eq && is_in && !have_r) begin
            have_nxt = 1'b1;
            net_nxt  = t_net[ri];
          end
          if (addr_eq && id_eq) begin
            net_nxt   = t_net[ri];
            fresh_nxt = 1'b0;
            st_nxt    = frx_pkg::B_HDR;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      frx_pkg::B_DECIDE: begin
        if (32'(cnt_r) >= TABLE_DEPTH) begin
          one_nxt = frx_pkg::KIND_FULL;
          st_nxt  = frx_pkg::B_ONE;
        end else begin
          if (is_in) begin
            w_net = have_r ? net_r : netc_r + 8'd1;
            if (!have_r) begin
              netc_nxt = netc_r + 8'd1;
            end
          end
          t_we      = 1'b1;
          net_nxt   = w_net;
          idx_nxt   = cnt_r;
          cnt_nxt   = cnt_r + CW'(1);
          fresh_nxt = 1'b1;
          st_nxt    = frx_pkg::B_HDR;
        end
      end
      frx_pkg::B_ONE: begin
        if (out_free) begin
          out_nxt = '{kind: one_r, entry_index: 4'd0, net_number: 8'd0, is_new: 1'b0,
                      data: 8'd0, last: 1'b1};
          ov_nxt  = 1'b1;
          st_nxt  = frx_pkg::B_DONE;
        end
      end
      frx_pkg::B_HDR: begin
        if (out_free) begin
          out_nxt = '{kind: frx_pkg::KIND_HDR, entry_index: 4'(idx_r), net_number: net_r,
                      is_new: fresh_r, data: 8'd0, last: pay_total == 8'd0};
          ov_nxt  = 1'b1;
          pay_nxt = '0;
          st_nxt  = (pay_total == 8'd0) ? frx_pkg::B_DONE : frx_pkg::B_RD;
        end
      end
      frx_pkg::B_RD: begin
        st_nxt = frx_pkg::B_PAY;
      end
      frx_pkg::B_PAY: begin
        if (out_free) begin
          out_nxt.kind = frx_pkg::KIND_PAY;
          out_nxt.data = rd_data;
          out_nxt.last = pay_r + 8'd1 == pay_total;
          ov_nxt       = 1'b1;
          pay_nxt      = pay_r + 8'd1;
          st_nxt       = out_nxt.last ? frx_pkg::B_DONE : frx_pkg::B_RD;
        end
      end
      frx_pkg::B_DONE: begin
        st_nxt = frx_pkg::B_IDLE;
      end
      default: begin
        st_nxt = frx_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= frx_pkg::B_IDLE;
      cnt_r  <= '0;
      netc_r <= 8'd1;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      netc_r <= netc_nxt;
      ov_r   <= ov_nxt;
    end
    idx_r   <= idx_nxt;
    net_r   <= net_nxt;
    have_r  <= have_nxt;
    fresh_r <= fresh_nxt;
    pay_r   <= pay_nxt;
    one_r   <= one_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      t_addr[cnt_r[IW-1:0]]  <= w_addr;
      t_wired[cnt_r[IW-1:0]] <= desc.wired;
      t_type[cnt_r[IW-1:0]]  <= desc.dev_type;
      t_net[cnt_r[IW-1:0]]   <= w_net;
    end
  end

endmodule

// File: rtl/core/frame_receiver_with_learning_table.sv
// Bus frame receiver with a learned device table. Each input transaction is
// one received byte (in_tuser = 0) or a gap timeout (in_tuser = 1). The parser
// hunts for 0x7E, takes a length byte and buffers that many body bytes; a
// timeout, a zero length or a length above FRAME_BYTES drops the frame. When
// a body completes, the parser hands it to the table engine and holds
// in_tready low until every result of that frame has been loaded into the
// output register. The engine answers a ping for own_id with a grant, and
// for a channel-filtered 'I' or 'O' frame walks the table one entry per
// cycle, learns an unknown device and emits a header followed by the payload,
// or reports a full table when an unknown device finds no free entry. Each
// payload byte is read from the registered frame buffer (state B_RD) before
// it is offered (B_PAY); the sink can stall any result. The table and frame
// buffer need no clearing after reset.
module frame_receiver_with_learning_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] entry_index, [11:4] net_number,
                                  // [12] is_new, [20:13] data, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last result of the frame
);

  logic [7:0] own_id_r, own_chan_r;
  logic       desc_valid, back_done;
  frx_pkg::frame_desc_t desc;
  frx_pkg::result_t     res;
  logic [$clog2(FRAME_BYTES)-1:0] rd_addr;
  logic [7:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= 8'd1;
      own_chan_r <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_index == frx_pkg::CFG_OWN_ID) begin
        own_id_r <= cfg_wdata;
      end else begin
        own_chan_r <= cfg_wdata;
      end
    end
  end

  // Front: byte parser and frame buffer
  frx_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_op      (in_tuser),
    .in_byte    (in_tdata),
    .in_ready   (in_tready),
    .desc_valid (desc_valid),
    .desc       (desc),
    .back_done  (back_done),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // Back: table walk, learning and result emission
  frx_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_id      (own_id_r),
    .own_channel (own_chan_r),
    .desc_valid  (desc_valid),
    .desc        (desc),
    .back_done   (back_done),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (out_tvalid),
    .res         (res),
    .res_ready   (out_tready)
  );

  assign out_tdata = {3'b000, res.data, res.is_new, res.net_number, res.entry_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// File: rtl/core/frx_checker.sv
module frx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == frx_pkg::KIND_GRANT || out_tuser == frx_pkg::KIND_FULL)
    |-> out_tlast && out_tdata == 24'd0)
    else $error("grant or table-full result malformed");

  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == frx_pkg::KIND_HDR |-> out_tdata[20:13] == 8'd0)
    else $error("header carries data");

endmodule

bind frame_receiver_with_learning_table frx_checker u_frx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
